@@ hw/rtl/assert_macros.svh @@
// ----------------------------------------------------------------------------
// Assertion macros for the sample framer RTL
// Clocked on clk, disabled while rst_n is low.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication
`define S2A_ASSERT_IMPL(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication
`define S2A_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ hw/rtl/s2a_pkg.sv @@
// ----------------------------------------------------------------------------
// s2a_pkg
// Shared types, constants and digit arithmetic for the sample framer.
// ----------------------------------------------------------------------------
package s2a_pkg;

    localparam int SAMPLE_W   = 16;
    localparam int DIGITS     = 4;
    localparam int NUM_STAGES = 2 * DIGITS;

    // Frame layout
    localparam int FRAME_LEN  = 7;
    localparam int BYTE_IDX_W = $clog2(FRAME_LEN);

    localparam logic [BYTE_IDX_W-1:0] POS_SYNC  = BYTE_IDX_W'(0);
    localparam logic [BYTE_IDX_W-1:0] POS_PAD   = BYTE_IDX_W'(1);
    localparam logic [BYTE_IDX_W-1:0] POS_D1000 = BYTE_IDX_W'(2);
    localparam logic [BYTE_IDX_W-1:0] POS_D100  = BYTE_IDX_W'(3);
    localparam logic [BYTE_IDX_W-1:0] POS_D10   = BYTE_IDX_W'(4);
    localparam logic [BYTE_IDX_W-1:0] POS_D1    = BYTE_IDX_W'(5);
    localparam logic [BYTE_IDX_W-1:0] POS_SPACE = BYTE_IDX_W'(6);

    localparam logic [7:0] SYNC_BYTE  = 8'hEE;
    localparam logic [7:0] PAD_BYTE   = 8'h00;
    localparam logic [7:0] SPACE_BYTE = 8'h20;
    localparam logic [7:0] DIGIT_BASE = 8'h30;

    // Divider codes, one per decimal weight
    localparam logic [1:0] DIV_10000 = 2'd0;
    localparam logic [1:0] DIV_1000  = 2'd1;
    localparam logic [1:0] DIV_100   = 2'd2;
    localparam logic [1:0] DIV_10    = 2'd3;

    // Queue between front and back
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    typedef struct packed {
        logic [DIGITS-1:0][3:0] digits;   // [3] is the thousands digit
        logic                   last;
    } s2a_entry_t;

    typedef struct packed {
        logic [SAMPLE_W-1:0]    rem;
        logic [3:0]             quot;
        logic [DIGITS-1:0][3:0] digits;
        logic                   last;
    } s2a_stage_t;

    // Quotient by reciprocal multiply; each range is bounded by the previous step
    function automatic logic [3:0] quot_digit(input logic [1:0] div_sel,
                                              input logic [SAMPLE_W-1:0] rem);
        logic [32:0] prod;
        logic [3:0]  q;
        prod = 33'd0;
        q    = 4'd0;
        unique case (div_sel)
            DIV_10000:
            begin
                prod = {17'd0, rem} * 33'd107375;
                q    = {1'b0, prod[32:30]};
            end
            DIV_1000:
            begin
                prod = {17'd0, rem} * 33'd16778;
                q    = prod[27:24];
            end
            DIV_100:
            begin
                prod = {17'd0, rem} * 33'd1311;
                q    = prod[20:17];
            end
            DIV_10:
            begin
                prod = {17'd0, rem} * 33'd205;
                q    = prod[14:11];
            end
            default:
            begin
                q = 4'd0;
            end
        endcase
        return q;
    endfunction

    function automatic logic [SAMPLE_W-1:0] rem_step(input logic [1:0] div_sel,
                                                     input logic [SAMPLE_W-1:0] rem,
                                                     input logic [3:0] q);
        logic [SAMPLE_W-1:0] prod;
        prod = '0;
        unique case (div_sel)
            DIV_10000: prod = {12'd0, q} * 16'd10000;
            DIV_1000:  prod = {12'd0, q} * 16'd1000;
            DIV_100:   prod = {12'd0, q} * 16'd100;
            DIV_10:    prod = {12'd0, q} * 16'd10;
            default:   prod = '0;
        endcase
        return rem - prod;
    endfunction

endpackage

@@ hw/rtl/sample_to_ascii_framer_top.sv @@
// ----------------------------------------------------------------------------
// sample_to_ascii_framer_top
// Formats each 16-bit sample as a 7-byte ASCII frame for a byte-wide link.
// ----------------------------------------------------------------------------
// Input channel: in_valid/in_ready carry sample and last_sample, one beat per
// sample. Output channel: out_valid/out_ready carry out_byte with frame_end and
// block_end, seven beats per sample: 0xEE, 0x00, four ASCII digits of the
// sample modulo 10000 (thousands first), then a space. frame_end marks the
// space byte; block_end marks it too when the sample came with last_sample.
// The first byte of a frame passes through the 8 digit stages, one queue
// slot and the output register after its sample is accepted into an idle
// block. The byte serialiser emits one output byte per cycle while out_ready
// is high and an entry is queued, setting the sample rate; the 8-stage digit
// pipeline accepts a sample every cycle until it and the 2-entry queue fill.
// Reset empties the pipeline, the queue and the output register; no frame is
// in flight afterwards and nothing needs initialising.
// While out_ready is low the current byte holds; the digit pipeline and queue
// keep taking samples until they are full, then in_ready drops.
// ----------------------------------------------------------------------------
module sample_to_ascii_framer_top (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [15:0] sample,
    input  logic        last_sample,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [7:0]  out_byte,
    output logic        frame_end,
    output logic        block_end
);

    logic                fq_valid, fq_ready;
    s2a_pkg::s2a_entry_t fq_data;
    logic                qb_valid, qb_ready;
    s2a_pkg::s2a_entry_t qb_data;

    s2a_front u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .sample      (sample),
        .last_sample (last_sample),
        .q_valid     (fq_valid),
        .q_ready     (fq_ready),
        .q_data      (fq_data)
    );

    s2a_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_valid (fq_valid),
        .wr_ready (fq_ready),
        .wr_data  (fq_data),
        .rd_valid (qb_valid),
        .rd_ready (qb_ready),
        .rd_data  (qb_data)
    );

    s2a_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .q_valid   (qb_valid),
        .q_ready   (qb_ready),
        .q_data    (qb_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_byte  (out_byte),
        .frame_end (frame_end),
        .block_end (block_end)
    );

endmodule

@@ hw/rtl/s2a_front.sv @@
// ----------------------------------------------------------------------------
// s2a_front
// Accepts samples and splits them into four decimal digits in a pipeline:
// quotient and remainder stages alternate for each decimal weight.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module s2a_front (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               in_valid,
    output logic                               in_ready,
    input  logic [s2a_pkg::SAMPLE_W-1:0]       sample,
    input  logic                               last_sample,
    output logic                               q_valid,
    input  logic                               q_ready,
    output s2a_pkg::s2a_entry_t                q_data
);

    s2a_pkg::s2a_stage_t src         [s2a_pkg::NUM_STAGES];
    logic                src_valid   [s2a_pkg::NUM_STAGES];
    logic                stage_ready [s2a_pkg::NUM_STAGES];
    s2a_pkg::s2a_stage_t st_reg      [s2a_pkg::NUM_STAGES];
    logic                valid_reg   [s2a_pkg::NUM_STAGES];

    for (genvar s = 0; s < s2a_pkg::NUM_STAGES; s++)
    begin : g_stage
        localparam logic [1:0] DIV_SEL   = 2'(s / 2);
        localparam int         DPOS      = (s / 2 == 0) ? 0 : s2a_pkg::DIGITS - s / 2;
        localparam bit         HAS_DIGIT = (s / 2 != 0);
        localparam bit         IS_LAST   = (s == s2a_pkg::NUM_STAGES - 1);

        s2a_pkg::s2a_stage_t nxt;
        logic                down_ready;
        logic                valid_next;

        if (s == 0)
        begin : g_src_in
            assign src[s]       = '{rem: sample, quot: 4'd0, digits: '0, last: last_sample};
            assign src_valid[s] = in_valid;
        end
        else
        begin : g_src_prev
            assign src[s]       = st_reg[s-1];
            assign src_valid[s] = valid_reg[s-1];
        end

        if (IS_LAST)
        begin : g_down_q
            assign down_ready = q_ready;
        end
        else
        begin : g_down_stage
            assign down_ready = stage_ready[s+1];
        end

        assign stage_ready[s] = !valid_reg[s] || down_ready;

        if (s % 2 == 0)
        begin : g_quot
            always_comb
            begin
                nxt      = src[s];
                nxt.quot = s2a_pkg::quot_digit(DIV_SEL, src[s].rem);
            end
        end
        else
        begin : g_rem
            always_comb
            begin
                nxt     = src[s];
                nxt.rem = s2a_pkg::rem_step(DIV_SEL, src[s].rem, src[s].quot);
                if (HAS_DIGIT)
                begin
                    nxt.digits[DPOS] = src[s].quot;
                end
                // the final remainder is the units digit
                if (IS_LAST)
                begin
                    nxt.digits[0] = nxt.rem[3:0];
                end
            end
        end

        assign valid_next = stage_ready[s] ? src_valid[s] : valid_reg[s];

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                valid_reg[s] <= 1'b0;
            end
            else
            begin
                valid_reg[s] <= valid_next;
            end
        end

        always_ff @(posedge clk)
        begin
            if (stage_ready[s] && src_valid[s])
            begin
                st_reg[s] <= nxt;
            end
        end
    end

    assign in_ready       = stage_ready[0];
    assign q_valid        = valid_reg[s2a_pkg::NUM_STAGES-1];
    assign q_data.digits  = st_reg[s2a_pkg::NUM_STAGES-1].digits;
    assign q_data.last    = st_reg[s2a_pkg::NUM_STAGES-1].last;

    `S2A_ASSERT_IMPL(a_digits_decimal, q_valid,
        (q_data.digits[3] <= 4'd9) && (q_data.digits[2] <= 4'd9) &&
        (q_data.digits[1] <= 4'd9) && (q_data.digits[0] <= 4'd9),
        "front produced a non-decimal digit")
    `S2A_ASSERT_NEXT(a_hold_when_blocked, q_valid && !q_ready, q_valid,
        "front dropped a finished entry while the queue was full")

endmodule

@@ hw/rtl/s2a_queue.sv @@
// ----------------------------------------------------------------------------
// s2a_queue
// Short FIFO of digit entries between the front and the back.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module s2a_queue (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                wr_valid,
    output logic                wr_ready,
    input  s2a_pkg::s2a_entry_t wr_data,
    output logic                rd_valid,
    input  logic                rd_ready,
    output s2a_pkg::s2a_entry_t rd_data
);

    s2a_pkg::s2a_entry_t              mem_reg [s2a_pkg::QUEUE_DEPTH];
    logic [s2a_pkg::QPTR_W-1:0]       wr_ptr_reg, wr_ptr_next;
    logic [s2a_pkg::QPTR_W-1:0]       rd_ptr_reg, rd_ptr_next;
    logic [s2a_pkg::QCNT_W-1:0]       count_reg, count_next;
    logic                             push, pop;

    localparam logic [s2a_pkg::QPTR_W-1:0] PTR_LAST = s2a_pkg::QPTR_W'(s2a_pkg::QUEUE_DEPTH - 1);
    localparam logic [s2a_pkg::QCNT_W-1:0] CNT_FULL = s2a_pkg::QCNT_W'(s2a_pkg::QUEUE_DEPTH);

    assign wr_ready = (count_reg != CNT_FULL);
    assign rd_valid = (count_reg != '0);
    assign rd_data  = mem_reg[rd_ptr_reg];
    assign push     = wr_valid && wr_ready;
    assign pop      = rd_valid && rd_ready;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_LAST) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_LAST) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= wr_data;
        end
    end

    `S2A_ASSERT_IMPL(a_count_bounded, 1'b1, count_reg <= CNT_FULL,
        "queue fill count above depth")

endmodule

@@ hw/rtl/s2a_back.sv @@
// ----------------------------------------------------------------------------
// s2a_back
// Serialises one queue entry into the seven frame bytes through a registered
// output stage; the entry is released with its last byte.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module s2a_back (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                q_valid,
    output logic                q_ready,
    input  s2a_pkg::s2a_entry_t q_data,
    output logic                out_valid,
    input  logic                out_ready,
    output logic [7:0]          out_byte,
    output logic                frame_end,
    output logic                block_end
);

    logic [s2a_pkg::BYTE_IDX_W-1:0] idx_reg, idx_next;
    logic                           out_valid_reg, out_valid_next;
    logic [7:0]                     out_byte_reg, byte_next;
    logic                           frame_end_reg, block_end_reg;
    logic                           load, at_end;

    assign load    = q_valid && (!out_valid_reg || out_ready);
    assign at_end  = (idx_reg == s2a_pkg::POS_SPACE);
    assign q_ready = load && at_end;

    always_comb
    begin
        unique case (idx_reg)
            s2a_pkg::POS_SYNC:  byte_next = s2a_pkg::SYNC_BYTE;
            s2a_pkg::POS_PAD:   byte_next = s2a_pkg::PAD_BYTE;
            s2a_pkg::POS_D1000: byte_next = s2a_pkg::DIGIT_BASE | {4'd0, q_data.digits[3]};
            s2a_pkg::POS_D100:  byte_next = s2a_pkg::DIGIT_BASE | {4'd0, q_data.digits[2]};
            s2a_pkg::POS_D10:   byte_next = s2a_pkg::DIGIT_BASE | {4'd0, q_data.digits[1]};
            s2a_pkg::POS_D1:    byte_next = s2a_pkg::DIGIT_BASE | {4'd0, q_data.digits[0]};
            s2a_pkg::POS_SPACE: byte_next = s2a_pkg::SPACE_BYTE;
            default:            byte_next = s2a_pkg::PAD_BYTE;
        endcase
    end

    always_comb
    begin
        idx_next       = idx_reg;
        out_valid_next = out_valid_reg;
        if (load)
        begin
            idx_next       = at_end ? s2a_pkg::POS_SYNC : idx_reg + 1'b1;
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg       <= s2a_pkg::POS_SYNC;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            idx_reg       <= idx_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            out_byte_reg  <= byte_next;
            frame_end_reg <= at_end;
            block_end_reg <= at_end && q_data.last;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_byte  = out_byte_reg;
    assign frame_end = frame_end_reg;
    assign block_end = block_end_reg;

    `S2A_ASSERT_IMPL(a_frame_end_on_space, out_valid_reg && frame_end_reg,
        out_byte_reg == s2a_pkg::SPACE_BYTE, "frame end flagged on a non-space byte")
    `S2A_ASSERT_IMPL(a_block_end_in_frame_end, out_valid_reg && block_end_reg,
        frame_end_reg, "block end flagged away from frame end")
    `S2A_ASSERT_NEXT(a_sync_after_release, q_ready, idx_reg == s2a_pkg::POS_SYNC,
        "byte counter not back at sync after entry release")

endmodule
